[rtl/id3_pkg.sv]
package id3_pkg;

    // Header mark "ID3"
    localparam logic [7:0] MARK_I = 8'h49;
    localparam logic [7:0] MARK_D = 8'h44;
    localparam logic [7:0] MARK_3 = 8'h33;

    // Frame identifiers of interest
    localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
    localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
    localparam logic [31:0] ID_TALB = 32'h5441_4C42;

    // Field kind codes
    localparam logic [1:0] KIND_TITLE  = 2'd0;
    localparam logic [1:0] KIND_ARTIST = 2'd1;
    localparam logic [1:0] KIND_ALBUM  = 2'd2;

    localparam int unsigned HDR_LEN   = 10;
    localparam int unsigned MAX_VER   = 4;
    localparam int unsigned Q_DEPTH   = 4;
    localparam int unsigned Q_AW      = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW      = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] text;
        logic       last;
    } text_item_t;

    function automatic logic [7:0] mark_byte(input logic [1:0] idx);
        logic [7:0] m;
        unique case (idx)
            2'd0:    m = MARK_I;
            2'd1:    m = MARK_D;
            default: m = MARK_3;
        endcase
        return m;
    endfunction

endpackage

[rtl/id3_parse.sv]
module id3_parse
    import id3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [7:0] data_byte,
    input  logic       file_start,
    output logic       item_valid,
    output text_item_t item
);

    localparam logic [2:0] PH_HDR  = 3'd0;
    localparam logic [2:0] PH_FHDR = 3'd1;
    localparam logic [2:0] PH_ENC  = 3'd2;
    localparam logic [2:0] PH_TEXT = 3'd3;
    localparam logic [2:0] PH_SKIP = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;

    localparam logic [3:0] LAST_HDR_BYTE = 4'(HDR_LEN - 1);

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic        sync_reg, sync_next;
    logic [27:0] tag_rem_reg, tag_rem_next;
    logic [31:0] frame_rem_reg, frame_rem_next;
    logic [31:0] frame_id_reg, frame_id_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  kind_reg, kind_next;

    // State as seen by this byte: a file start restarts the parser first.
    logic [2:0]  ph;
    logic [3:0]  bc;
    logic        ss;
    logic [27:0] tr;
    logic [31:0] fr;
    logic [31:0] fid;
    logic [31:0] acc;
    logic [1:0]  kd;
    logic        known;
    logic [1:0]  id_kind;

    always_comb
    begin
        if (file_start)
        begin
            ph  = PH_HDR;
            bc  = '0;
            ss  = 1'b0;
            tr  = '0;
            fr  = '0;
            fid = '0;
            acc = '0;
            kd  = '0;
        end
        else
        begin
            ph  = phase_reg;
            bc  = count_reg;
            ss  = sync_reg;
            tr  = tag_rem_reg;
            fr  = frame_rem_reg;
            fid = frame_id_reg;
            acc = acc_reg;
            kd  = kind_reg;
        end
    end

    always_comb
    begin
        known   = 1'b1;
        id_kind = KIND_TITLE;
        priority if (fid == ID_TIT2)
            id_kind = KIND_TITLE;
        else if (fid == ID_TPE1)
            id_kind = KIND_ARTIST;
        else if (fid == ID_TALB)
            id_kind = KIND_ALBUM;
        else
            known = 1'b0;
    end

    always_comb
    begin
        phase_next     = ph;
        count_next     = bc;
        sync_next      = ss;
        tag_rem_next   = tr;
        frame_rem_next = fr;
        frame_id_next  = fid;
        acc_next       = acc;
        kind_next      = kd;
        item_valid     = 1'b0;
        item.kind      = kd;
        item.text      = data_byte;
        item.last      = 1'b0;

        unique case (ph)
            PH_HDR:
            begin
                if ((bc < 4'd3 && data_byte != mark_byte(bc[1:0]))
                    || (bc == 4'd3 && data_byte > 8'(MAX_VER))
                    || (bc == 4'd5 && data_byte != 8'd0)
                    || (bc >= 4'd6 && data_byte[7]))
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    if (bc == 4'd3)
                        sync_next = (data_byte == 8'(MAX_VER));
                    if (bc >= 4'd6)
                        acc_next = {4'd0, acc[20:0], data_byte[6:0]};
                    if (bc >= LAST_HDR_BYTE)
                    begin
                        tag_rem_next = acc_next[27:0];
                        acc_next     = '0;
                        count_next   = '0;
                        phase_next   = (acc_next[27:0] != 28'd0) ? PH_FHDR : PH_DONE;
                        if (bc >= 4'd6)
                        begin
                            tag_rem_next = {acc[20:0], data_byte[6:0]};
                            phase_next   = ({acc[20:0], data_byte[6:0]} != 28'd0)
                                           ? PH_FHDR : PH_DONE;
                        end
                    end
                    else
                    begin
                        count_next = bc + 4'd1;
                    end
                end
            end

            PH_FHDR:
            begin
                // A zero first byte is padding; a flagged syncsafe size byte aborts.
                if ((bc == 4'd0 && data_byte == 8'd0)
                    || (ss && bc >= 4'd4 && bc < 4'd8 && data_byte[7]))
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    tag_rem_next = tr - 28'd1;
                    if (bc < 4'd4)
                        frame_id_next = {fid[23:0], data_byte};
                    else if (bc < 4'd8)
                        acc_next = ss ? {acc[24:0], data_byte[6:0]} : {acc[23:0], data_byte};
                    if (bc >= LAST_HDR_BYTE)
                    begin
                        frame_rem_next = acc;
                        acc_next       = '0;
                        count_next     = '0;
                        if (tag_rem_next == 28'd0)
                            phase_next = PH_DONE;
                        else
                            phase_next = (acc != 32'd0) ? PH_ENC : PH_FHDR;
                    end
                    else
                    begin
                        count_next = bc + 4'd1;
                        if (tag_rem_next == 28'd0)
                            phase_next = PH_DONE;
                    end
                end
            end

            PH_ENC, PH_TEXT, PH_SKIP:
            begin
                tag_rem_next   = tr - 28'd1;
                frame_rem_next = fr - 32'd1;
                if (ph == PH_ENC)
                begin
                    if (known)
                        kind_next = id_kind;
                    phase_next = (known && data_byte <= 8'd1) ? PH_TEXT : PH_SKIP;
                end
                if (ph == PH_TEXT)
                begin
                    item_valid = en;
                    item.last  = (tag_rem_next == 28'd0) || (frame_rem_next == 32'd0);
                end
                if (tag_rem_next == 28'd0)
                    phase_next = PH_DONE;
                else if (frame_rem_next == 32'd0)
                    phase_next = PH_FHDR;
            end

            default:
            begin
                phase_next = ph;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR;
            count_reg     <= '0;
            sync_reg      <= 1'b0;
            tag_rem_reg   <= '0;
            frame_rem_reg <= '0;
            frame_id_reg  <= '0;
            acc_reg       <= '0;
            kind_reg      <= '0;
        end
        else if (en)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            sync_reg      <= sync_next;
            tag_rem_reg   <= tag_rem_next;
            frame_rem_reg <= frame_rem_next;
            frame_id_reg  <= frame_id_next;
            acc_reg       <= acc_next;
            kind_reg      <= kind_next;
        end
    end

endmodule

[rtl/id3_fifo.sv]
module id3_fifo
    import id3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  text_item_t wr_item,
    input  logic       rd_en,
    output text_item_t rd_item,
    output logic       full,
    output logic       empty
);

    localparam logic [Q_AW-1:0] LAST_PTR   = Q_AW'(Q_DEPTH - 1);
    localparam logic [Q_CW-1:0] FULL_COUNT = Q_CW'(Q_DEPTH);

    text_item_t          slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]     count_reg, count_next;

    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign rd_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/id3v2_text_frame_extractor.sv]
// Pulls title, artist and album text out of the ID3v2 tag at the head of a
// byte stream. File bytes enter through a queue-style port (push/full,
// data_byte, file_start); file_start marks the first byte of each file and
// restarts the parser. Text bytes leave through a queue-style port
// (empty/pop) as field_kind, text_byte and field_last, the latter set on
// the final text byte of a frame or of the tag.
// Each accepted byte is parsed in the cycle it is accepted; a text byte is
// registered into a four-entry result queue whose head drives the result
// ports. Throughput is one byte per cycle while full is low, as the parser
// updates on every accepted byte; bytes that yield no text simply advance
// the parser.
// When the receiver stops popping, the result queue fills and full rises,
// holding back further bytes until an entry is taken.
// After reset the queue is empty and the parser expects header byte zero.
module id3v2_text_frame_extractor
    import id3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       file_start,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] field_kind,
    output logic [7:0] text_byte,
    output logic       field_last
);

    logic       accept;
    logic       item_valid;
    text_item_t item;
    text_item_t head;

    assign accept = push && !full;

    id3_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (accept),
        .data_byte  (data_byte),
        .file_start (file_start),
        .item_valid (item_valid),
        .item       (item)
    );

    id3_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (item_valid),
        .wr_item (item),
        .rd_en   (pop && !empty),
        .rd_item (head),
        .full    (full),
        .empty   (empty)
    );

    assign field_kind = head.kind;
    assign text_byte  = head.text;
    assign field_last = head.last;

endmodule

[rtl/id3_checker.sv]
module id3_checker
    import id3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] data_byte,
    input  logic       file_start,
    input  logic       empty,
    input  logic       pop,
    input  logic [1:0] field_kind,
    input  logic [7:0] text_byte,
    input  logic       field_last
);

    // The queue is cleared by reset; while reset stays low it must read empty.
    a_reset_empty: assert property (@(posedge clk) (!rst_n ##1 !rst_n) |-> empty)
        else $error("result queue not empty during reset");

    // Results never appear without a byte request.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !(push && !full)) |=> empty)
        else $error("result appeared without an accepted byte");

    // A full queue holds at least one result.
    a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("full raised with an empty queue");

    a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (field_kind == KIND_TITLE || field_kind == KIND_ARTIST
                    || field_kind == KIND_ALBUM))
        else $error("unknown field kind on result port");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(text_byte) && $stable(field_kind)
                              && $stable(field_last)))
        else $error("stalled result changed");

endmodule

bind id3v2_text_frame_extractor id3_checker u_checker (.*);
